// ===== src/humidity_pressure_temp_compensation_assert.svh =====
// Assertion macros for the compensation block's port checker.
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define HPT_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define HPT_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/hpt_pkg.sv =====
// Types, register indexes and helper functions of the compensation block.
package hpt_pkg;

	typedef logic signed [31:0] s32_t;

	localparam int DIV_W = 32;

	localparam logic [2:0] CFG_TEMP    = 3'd0;
	localparam logic [2:0] CFG_PRESS_A = 3'd1;
	localparam logic [2:0] CFG_PRESS_B = 3'd2;
	localparam logic [2:0] CFG_P9      = 3'd3;
	localparam logic [2:0] CFG_HUM     = 3'd4;

	typedef struct packed {
		logic [19:0] temp_raw;
		logic [19:0] pressure_raw;
		logic [15:0] humidity_raw;
	} hpt_in_t;

	typedef struct packed {
		logic signed [14:0] temperature;
		logic [16:0]        pressure;
		logic [16:0]        humidity;
	} hpt_out_t;

	// Finished fields that ride along the divider with the pressure quotient.
	typedef struct packed {
		logic signed [14:0] temperature;
		logic [16:0]        humidity;
		logic               zero;
		logic               dbl;
	} hpt_side_t;

	// Signed divide by 2^k, truncating toward zero.
	function automatic s32_t sdiv_p2(input s32_t x, input logic [4:0] k);
		logic [31:0] mask;
		s32_t        sum;
		mask = ~(32'hFFFF_FFFF << k);
		sum  = x + s32_t'(mask & {32{x[31]}});
		return sum >>> k;
	endfunction

endpackage

// ===== src/humidity_pressure_temp_compensation.sv =====
// Top level: 32-bit integer temperature, pressure and humidity compensation.
// Throughput: one item per cycle; 14 arithmetic stages, a 32-stage pressure divider
// (one quotient bit per stage) and 3 pressure tail stages, all moving together.
// A stalled output holds the whole pipeline; bubbles are kept, nothing is lost.
// Reset clears the valid bits and the calibration registers (all zero).
module humidity_pressure_temp_compensation (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr,
	input  logic [2:0]       cfg_addr,
	input  logic [63:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  hpt_pkg::hpt_in_t sample,
	output logic             out_valid,
	input  logic             out_stall,
	output hpt_pkg::hpt_out_t result
);

	// ---------------------------------------------------------------
	// Calibration registers
	// ---------------------------------------------------------------
	logic [47:0] temp_calib_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] p9_q;
	logic [63:0] hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			p9_q         <= '0;
			hum_q        <= '0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				hpt_pkg::CFG_TEMP:    temp_calib_q <= cfg_data[47:0];
				hpt_pkg::CFG_PRESS_A: press_a_q    <= cfg_data;
				hpt_pkg::CFG_PRESS_B: press_b_q    <= cfg_data;
				hpt_pkg::CFG_P9:      p9_q         <= cfg_data[15:0];
				hpt_pkg::CFG_HUM:     hum_q        <= cfg_data;
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// Unpack coefficients, extended to the 32-bit datapath.
	hpt_pkg::s32_t t1, t2, t3;
	hpt_pkg::s32_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
	hpt_pkg::s32_t h1, h2, h3, h4, h5, h6;

	assign t1 = {16'b0, temp_calib_q[15:0]};
	assign t2 = {{16{temp_calib_q[31]}}, temp_calib_q[31:16]};
	assign t3 = {{16{temp_calib_q[47]}}, temp_calib_q[47:32]};
	assign p1 = {16'b0, press_a_q[15:0]};
	assign p2 = {{16{press_a_q[31]}}, press_a_q[31:16]};
	assign p3 = {{16{press_a_q[47]}}, press_a_q[47:32]};
	assign p4 = {{16{press_a_q[63]}}, press_a_q[63:48]};
	assign p5 = {{16{press_b_q[15]}}, press_b_q[15:0]};
	assign p6 = {{16{press_b_q[31]}}, press_b_q[31:16]};
	assign p7 = {{16{press_b_q[47]}}, press_b_q[47:32]};
	assign p8 = {{16{press_b_q[63]}}, press_b_q[63:48]};
	assign p9 = {{16{p9_q[15]}}, p9_q};
	assign h1 = {24'b0, hum_q[7:0]};
	assign h2 = {{16{hum_q[23]}}, hum_q[23:8]};
	assign h3 = {24'b0, hum_q[31:24]};
	assign h4 = {{20{hum_q[43]}}, hum_q[43:32]};
	assign h5 = {{20{hum_q[55]}}, hum_q[55:44]};
	assign h6 = {{24{hum_q[63]}}, hum_q[63:56]};

	// ---------------------------------------------------------------
	// Flow control: every stage advances together unless the output
	// register holds an item that is being stalled.
	// ---------------------------------------------------------------
	logic adv;
	logic [1:14] vld_s;
	logic vld_s15, vld_s16, vld_s17;
	logic div_vld;

	assign adv      = !vld_s17 || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else if (adv) begin
			vld_s   <= {in_valid, vld_s[1:13]};
			vld_s15 <= div_vld;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
		end
	end

	// ---------------------------------------------------------------
	// Stages 1..4: fine temperature
	// ---------------------------------------------------------------
	hpt_pkg::s32_t tx_s1, ty_s1, m1_s2, m2_s2, ta_s3, m3_s3, tf_s4;
	logic [19:0]   praw_s1, praw_s2, praw_s3, praw_s4, praw_s5, praw_s6;
	logic [19:0]   praw_s7, praw_s8, praw_s9;
	logic [15:0]   hraw_s1, hraw_s2, hraw_s3, hraw_s4;

	// Stage 5: temperature result, pressure and humidity entry
	hpt_pkg::s32_t tcalc, tclamp, pa0, hv1;
	hpt_pkg::s32_t pa_s5, pq_s5, hv1_s5, hbase_s5;
	logic signed [14:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic signed [14:0] temp_s11, temp_s12, temp_s13, temp_s14;

	always_comb begin
		tcalc  = hpt_pkg::sdiv_p2(tf_s4 * 32'sd5 + 32'sd128, 5'd8);
		tclamp = tcalc;
		if (tcalc < -32'sd4000) begin
			tclamp = -32'sd4000;
		end else if (tcalc > 32'sd8500) begin
			tclamp = 32'sd8500;
		end
		pa0 = hpt_pkg::sdiv_p2(tf_s4, 5'd1) - 32'sd64000;
		hv1 = tf_s4 - 32'sd76800;
	end

	// Pressure stages 6..14
	hpt_pkg::s32_t qq_s6, ap5_s6, p2a_s6;
	hpt_pkg::s32_t b1m_s7, c1m_s7, ap5_s7, d_s7;
	hpt_pkg::s32_t pb_s8, a2_s8, pb_s9, pm1_s9;
	logic [31:0]   div_s10, pp_s10, p3125_s11;
	logic [31:0]   div_s11, div_s12, div_s13, div_s14;
	logic [31:0]   num_s12, num_s13, num_s14;
	logic          zero_s10, zero_s11, zero_s12, zero_s13, zero_s14;
	logic          dbl_s12, dbl_s13, dbl_s14;

	hpt_pkg::s32_t pb_c, pb_d, pa_c, pdiv_c;
	logic [31:0]   pr_c;

	always_comb begin
		pb_c   = b1m_s7 + (ap5_s7 <<< 1);
		pb_d   = hpt_pkg::sdiv_p2(pb_c, 5'd2) + (p4 <<< 16);
		pa_c   = hpt_pkg::sdiv_p2(hpt_pkg::sdiv_p2(c1m_s7, 5'd3) + d_s7, 5'd18);
		pdiv_c = hpt_pkg::sdiv_p2(pm1_s9, 5'd15);
		pr_c   = 32'd1048576 - {12'b0, praw_s9};
	end

	// Humidity stages 6..14
	hpt_pkg::s32_t hbase_s6, h5v_s6, m6_s6, m3h_s6;
	hpt_pkg::s32_t hv5_s7, hv2_s7, hv3_s7;
	hpt_pkg::s32_t hv5_s8, hm_s8, hv5_s9, hmm_s9, hv5_s10, hv2_s10;
	hpt_pkg::s32_t hv3_s11, hv3_s12, hsq_s12, hv3_s13, hmh_s13;
	logic [16:0]   hum_s14;

	hpt_pkg::s32_t hs_c, hfin, hcl;

	always_comb begin
		hs_c = hpt_pkg::sdiv_p2(hv3_s11, 5'd15);
		hfin = hv3_s13 - hpt_pkg::sdiv_p2(hmh_s13, 5'd4);
		hcl  = hfin;
		if (hfin < 32'sd0) begin
			hcl = 32'sd0;
		end else if (hfin > 32'sd419430400) begin
			hcl = 32'sd419430400;
		end
		hcl = hcl >>> 12;
		if (hcl > 32'sd102400) begin
			hcl = 32'sd102400;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// temperature chain
			tx_s1   <= hpt_pkg::s32_t'({15'b0, sample.temp_raw[19:3]}) - (t1 <<< 1);
			ty_s1   <= hpt_pkg::s32_t'({16'b0, sample.temp_raw[19:4]}) - t1;
			praw_s1 <= sample.pressure_raw;
			hraw_s1 <= sample.humidity_raw;

			m1_s2   <= tx_s1 * t2;
			m2_s2   <= ty_s1 * ty_s1;
			praw_s2 <= praw_s1;
			hraw_s2 <= hraw_s1;

			ta_s3   <= hpt_pkg::sdiv_p2(m1_s2, 5'd11);
			m3_s3   <= hpt_pkg::sdiv_p2(m2_s2, 5'd12) * t3;
			praw_s3 <= praw_s2;
			hraw_s3 <= hraw_s2;

			tf_s4   <= ta_s3 + hpt_pkg::sdiv_p2(m3_s3, 5'd14);
			praw_s4 <= praw_s3;
			hraw_s4 <= hraw_s3;

			// split into temperature, pressure and humidity
			temp_s5  <= tclamp[14:0];
			pa_s5    <= pa0;
			pq_s5    <= hpt_pkg::sdiv_p2(pa0, 5'd2);
			praw_s5  <= praw_s4;
			hv1_s5   <= hv1;
			hbase_s5 <= hpt_pkg::s32_t'({2'b0, hraw_s4, 14'b0}) - (h4 <<< 20);

			// pressure
			qq_s6   <= pq_s5 * pq_s5;
			ap5_s6  <= pa_s5 * p5;
			p2a_s6  <= p2 * pa_s5;
			praw_s6 <= praw_s5;

			b1m_s7  <= hpt_pkg::sdiv_p2(qq_s6, 5'd11) * p6;
			c1m_s7  <= p3 * hpt_pkg::sdiv_p2(qq_s6, 5'd13);
			ap5_s7  <= ap5_s6;
			d_s7    <= hpt_pkg::sdiv_p2(p2a_s6, 5'd1);
			praw_s7 <= praw_s6;

			pb_s8   <= pb_d;
			a2_s8   <= 32'sd32768 + pa_c;
			praw_s8 <= praw_s7;

			pb_s9   <= pb_s8;
			pm1_s9  <= a2_s8 * p1;
			praw_s9 <= praw_s8;

			div_s10  <= pdiv_c;
			zero_s10 <= (pdiv_c == 32'sd0);
			pp_s10   <= pr_c - hpt_pkg::sdiv_p2(pb_s9, 5'd12);

			p3125_s11 <= pp_s10 * 32'd3125;
			div_s11   <= div_s10;
			zero_s11  <= zero_s10;

			// a dividend at or above 2^31 is divided first and doubled later
			num_s12  <= p3125_s11[31] ? p3125_s11 : {p3125_s11[30:0], 1'b0};
			dbl_s12  <= p3125_s11[31];
			div_s12  <= div_s11;
			zero_s12 <= zero_s11;

			num_s13  <= num_s12;
			dbl_s13  <= dbl_s12;
			div_s13  <= div_s12;
			zero_s13 <= zero_s12;

			num_s14  <= num_s13;
			dbl_s14  <= dbl_s13;
			div_s14  <= div_s13;
			zero_s14 <= zero_s13;

			// humidity
			hbase_s6 <= hbase_s5;
			h5v_s6   <= h5 * hv1_s5;
			m6_s6    <= hv1_s5 * h6;
			m3h_s6   <= hv1_s5 * h3;

			hv5_s7 <= hpt_pkg::sdiv_p2(hbase_s6 - h5v_s6 + 32'sd16384, 5'd15);
			hv2_s7 <= hpt_pkg::sdiv_p2(m6_s6, 5'd10);
			hv3_s7 <= hpt_pkg::sdiv_p2(m3h_s6, 5'd11) + 32'sd32768;

			hv5_s8 <= hv5_s7;
			hm_s8  <= hv2_s7 * hv3_s7;

			hv5_s9 <= hv5_s8;
			hmm_s9 <= (hpt_pkg::sdiv_p2(hm_s8, 5'd10) + 32'sd2097152) * h2;

			hv5_s10 <= hv5_s9;
			hv2_s10 <= hpt_pkg::sdiv_p2(hmm_s9 + 32'sd8192, 5'd14);

			hv3_s11 <= hv5_s10 * hv2_s10;

			hv3_s12 <= hv3_s11;
			hsq_s12 <= hs_c * hs_c;

			hv3_s13 <= hv3_s12;
			hmh_s13 <= hpt_pkg::sdiv_p2(hsq_s12, 5'd7) * h1;

			hum_s14 <= hcl[16:0];

			// carry the finished temperature down to the divider
			temp_s6  <= temp_s5;
			temp_s7  <= temp_s6;
			temp_s8  <= temp_s7;
			temp_s9  <= temp_s8;
			temp_s10 <= temp_s9;
			temp_s11 <= temp_s10;
			temp_s12 <= temp_s11;
			temp_s13 <= temp_s12;
			temp_s14 <= temp_s13;
		end
	end

	// ---------------------------------------------------------------
	// Pressure divider, 32 stages
	// ---------------------------------------------------------------
	hpt_pkg::hpt_side_t side_in, side_out;
	logic [31:0]        quo;

	assign side_in.temperature = temp_s14;
	assign side_in.humidity    = hum_s14;
	assign side_in.zero        = zero_s14;
	assign side_in.dbl         = dbl_s14;

	hpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s[14]),
		.num      (num_s14),
		.den      (div_s14),
		.side     (side_in),
		.out_vld  (div_vld),
		.quo      (quo),
		.side_out (side_out)
	);

	// ---------------------------------------------------------------
	// Stages 15..17: pressure correction and clamp
	// ---------------------------------------------------------------
	logic [31:0]        pq_c, pd8_c;
	logic [31:0]        p_s15, sq_s15, p_s16;
	hpt_pkg::s32_t      pm_s15, a9m_s16, bb_s16;
	hpt_pkg::hpt_side_t side_s15, side_s16;
	hpt_pkg::s32_t      pc_c;
	logic [31:0]        pf_c, pout_c;
	hpt_pkg::hpt_out_t  res_s17;

	always_comb begin
		pq_c  = side_out.dbl ? {quo[30:0], 1'b0} : quo;
		pd8_c = {3'b0, pq_c[31:3]};
		pc_c  = hpt_pkg::sdiv_p2(hpt_pkg::sdiv_p2(a9m_s16, 5'd12) + bb_s16 + p7, 5'd4);
		pf_c  = p_s16 + pc_c;
		if (side_s16.zero || pf_c < 32'd30000) begin
			pout_c = 32'd30000;
		end else if (pf_c > 32'd110000) begin
			pout_c = 32'd110000;
		end else begin
			pout_c = pf_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s15    <= pq_c;
			sq_s15   <= pd8_c * pd8_c;
			pm_s15   <= hpt_pkg::s32_t'({2'b0, pq_c[31:2]}) * p8;
			side_s15 <= side_out;

			p_s16    <= p_s15;
			a9m_s16  <= p9 * hpt_pkg::s32_t'({13'b0, sq_s15[31:13]});
			bb_s16   <= hpt_pkg::sdiv_p2(pm_s15, 5'd13);
			side_s16 <= side_s15;

			res_s17.temperature <= side_s16.temperature;
			res_s17.pressure    <= pout_c[16:0];
			res_s17.humidity    <= side_s16.humidity;
		end
	end

	assign out_valid = vld_s17;
	assign result    = res_s17;

endmodule

// ===== src/hpt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module hpt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [31:0]       num,
	input  logic [31:0]       den,
	input  hpt_pkg::hpt_side_t side,
	output logic              out_vld,
	output logic [31:0]       quo,
	output hpt_pkg::hpt_side_t side_out
);

	localparam int W = hpt_pkg::DIV_W;

	logic [W-1:0]       rem_s  [W];
	logic [W-1:0]       nq_s   [W];
	logic [W-1:0]       den_s  [W];
	hpt_pkg::hpt_side_t side_s [W];
	logic [W-1:0]       vld_s;

	genvar k;
	for (k = 0; k < W; k++) begin : g_st
		logic [W-1:0]       rem_i, nq_i, den_i;
		hpt_pkg::hpt_side_t side_i;
		logic               vld_i;
		logic [W:0]         trial, diff;
		logic               take;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign nq_i   = num;
			assign den_i  = den;
			assign side_i = side;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign nq_i   = nq_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign trial = {rem_i, nq_i[W-1]};
		assign diff  = trial - {1'b0, den_i};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[W-1:0] : trial[W-1:0];
				nq_s[k]   <= {nq_i[W-2:0], take};
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end
	end

	assign out_vld  = vld_s[W-1];
	assign quo      = nq_s[W-1];
	assign side_out = side_s[W-1];

endmodule

// ===== src/hpt_chk.sv =====
// Port checker for the compensation block, bound to the top level.
`include "humidity_pressure_temp_compensation_assert.svh"

module hpt_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input hpt_pkg::hpt_out_t result
);

	`HPT_ASSERT_IMP(a_temp_range, out_valid, (result.temperature >= -15'sd4000) && (result.temperature <= 15'sd8500), "temperature out of range")
	`HPT_ASSERT_IMP(a_press_range, out_valid, (result.pressure >= 17'd30000) && (result.pressure <= 17'd110000), "pressure out of range")
	`HPT_ASSERT_IMP(a_hum_range, out_valid, result.humidity <= 17'd102400, "humidity out of range")
	`HPT_ASSERT_IMP(a_stall_link, 1'b1, in_stall == (out_valid && out_stall), "input stall not tied to held output")
	`HPT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result), "stalled item changed")

endmodule

bind humidity_pressure_temp_compensation hpt_chk u_chk (.*);

// ===== tb/sv/compensation_checker.sv =====
// Checker for the compensation block: predicts each sample's result and compares it.
`timescale 1ns / 100ps
module compensation_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr,
	input  logic [2:0]        cfg_addr,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  hpt_pkg::hpt_in_t  sample,
	input  logic              out_valid,
	input  logic              out_stall,
	input  hpt_pkg::hpt_out_t result,
	output int                errors,
	output int                outstanding
);
	import hpt_pkg::*;

	logic [47:0] temp_cal;
	logic [63:0] press_cal_a, press_cal_b, hum_cal;
	logic [15:0] p9_cal;
	hpt_out_t    expected_q[$];

	function automatic longint wrap(longint x);
		logic signed [31:0] v;
		v = x[31:0];
		return v;
	endfunction

	function automatic hpt_out_t compensate(hpt_in_t s);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint h1, h2, h3, h4, h5, h6;
		longint a, b, c, d, q, tf, t, v1, v2, v3, v4, v5;
		logic [31:0] p, dv, r, pq;
		hpt_out_t o;
		t1 = longint'(temp_cal[15:0]);
		t2 = longint'($signed(temp_cal[31:16]));
		t3 = longint'($signed(temp_cal[47:32]));
		p1 = longint'(press_cal_a[15:0]);
		p2 = longint'($signed(press_cal_a[31:16]));
		p3 = longint'($signed(press_cal_a[47:32]));
		p4 = longint'($signed(press_cal_a[63:48]));
		p5 = longint'($signed(press_cal_b[15:0]));
		p6 = longint'($signed(press_cal_b[31:16]));
		p7 = longint'($signed(press_cal_b[47:32]));
		p8 = longint'($signed(press_cal_b[63:48]));
		p9 = longint'($signed(p9_cal));
		h1 = longint'(hum_cal[7:0]);
		h2 = longint'($signed(hum_cal[23:8]));
		h3 = longint'(hum_cal[31:24]);
		h4 = longint'($signed(hum_cal[43:32]));
		h5 = longint'($signed(hum_cal[55:44]));
		h6 = longint'($signed(hum_cal[63:56]));

		// fine temperature, shared by all three outputs
		a = wrap(longint'(s.temp_raw / 8) - wrap(t1 * 2));
		a = wrap(a * t2) / 2048;
		b = wrap(longint'(s.temp_raw / 16) - t1);
		b = wrap(wrap(b * b) / 4096 * t3) / 16384;
		tf = wrap(a + b);
		t = wrap(wrap(tf * 5) + 128) / 256;
		if (t < -4000) t = -4000;
		else if (t > 8500) t = 8500;
		o.temperature = t[14:0];

		// pressure
		a = wrap(tf / 2 - 64000);
		q = a / 4;
		b = wrap(wrap(q * q) / 2048 * p6);
		b = wrap(b + wrap(wrap(a * p5) * 2));
		b = wrap(b / 4 + wrap(p4 * 65536));
		c = wrap(p3 * (wrap(q * q) / 8192)) / 8;
		d = wrap(p2 * a) / 2;
		a = wrap(c + d) / 262144;
		a = wrap(wrap(32768 + a) * p1) / 32768;
		if (a == 0) begin
			o.pressure = 17'd30000;
		end else begin
			dv = a[31:0];
			r = 32'd1048576 - 32'(s.pressure_raw);
			d = b / 4096;
			p = (r - d[31:0]) * 32'd3125;
			// large dividend: divide first, then double
			if (p < 32'h8000_0000) p = (p << 1) / dv;
			else p = (p / dv) * 32'd2;
			pq = (p / 8) * (p / 8);
			a = wrap(p9 * longint'(pq / 8192)) / 4096;
			b = wrap(longint'(p / 4) * p8) / 8192;
			c = wrap(wrap(a + b) + p7) / 16;
			d = wrap(wrap(longint'(p)) + c);
			p = d[31:0];
			if (p < 32'd30000) p = 32'd30000;
			else if (p > 32'd110000) p = 32'd110000;
			o.pressure = p[16:0];
		end

		// humidity
		v1 = wrap(tf - 76800);
		v2 = wrap(longint'(s.humidity_raw) * 16384);
		v3 = wrap(h4 * 1048576);
		v4 = wrap(h5 * v1);
		v5 = wrap(wrap(wrap(v2 - v3) - v4) + 16384) / 32768;
		v2 = wrap(v1 * h6) / 1024;
		v3 = wrap(v1 * h3) / 2048;
		v4 = wrap(wrap(v2 * wrap(v3 + 32768)) / 1024 + 2097152);
		v2 = wrap(wrap(v4 * h2) + 8192) / 16384;
		v3 = wrap(v5 * v2);
		v4 = wrap((v3 / 32768) * (v3 / 32768)) / 128;
		v5 = wrap(v3 - wrap(v4 * h1) / 16);
		if (v5 < 0) v5 = 0;
		if (v5 > 419430400) v5 = 419430400;
		v5 = v5 / 4096;
		if (v5 > 102400) v5 = 102400;
		o.humidity = v5[16:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hpt_out_t e;
		if (!arst_n) begin
			temp_cal    <= '0;
			press_cal_a <= '0;
			press_cal_b <= '0;
			p9_cal      <= '0;
			hum_cal     <= '0;
			errors      = 0;
			outstanding = 0;
			expected_q.delete();
		end else begin
			if (cfg_wr) begin
				case (cfg_addr)
					CFG_TEMP:    temp_cal    <= cfg_data[47:0];
					CFG_PRESS_A: press_cal_a <= cfg_data;
					CFG_PRESS_B: press_cal_b <= cfg_data;
					CFG_P9:      p9_cal      <= cfg_data[15:0];
					CFG_HUM:     hum_cal     <= cfg_data;
					default:     ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(compensate(sample));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item %p", result);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (result.temperature !== e.temperature) begin
						$error("temperature: expected %0d, got %0d",
							e.temperature, result.temperature);
						errors++;
					end
					if (result.pressure !== e.pressure) begin
						$error("pressure: expected %0d, got %0d", e.pressure, result.pressure);
						errors++;
					end
					if (result.humidity !== e.humidity) begin
						$error("humidity: expected %0d, got %0d", e.humidity, result.humidity);
						errors++;
					end
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the compensation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
	import hpt_pkg::*;

	// index with no register behind it; writes there must be ignored
	localparam logic [2:0] CFG_NONE = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	// typical factory calibration words
	localparam logic [47:0] TYP_TEMP  = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [63:0] TYP_PA    = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
	localparam logic [63:0] TYP_PB    = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
	localparam logic [15:0] TYP_P9    = 16'd6000;
	localparam logic [63:0] TYP_HUM   = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

	logic     clk, arst_n;
	logic     cfg_wr;
	logic [2:0]  cfg_addr;
	logic [63:0] cfg_data;
	logic     in_valid, in_stall, out_valid, out_stall;
	hpt_in_t  sample;
	hpt_out_t result;
	int       errors, outstanding;
	int       cycles;
	bit       calm;   // no idling on either side while set
	int       stall_left;

	humidity_pressure_temp_compensation dut (
		.clk, .arst_n, .cfg_wr, .cfg_addr, .cfg_data,
		.in_valid, .in_stall, .sample, .out_valid, .out_stall, .result
	);

	compensation_checker chk (
		.clk, .arst_n, .cfg_wr, .cfg_addr, .cfg_data,
		.in_valid, .in_stall, .sample, .out_valid, .out_stall, .result,
		.errors, .outstanding
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Randomly stall the result side after each taken item, unless calm.
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= (stall_left > 0);
		end else if (out_valid && !out_stall) begin
			n = calm ? 0 : $urandom_range(0, 3);
			stall_left = n;
			out_stall <= (n > 0);
		end
	end

	// Watchdog: give up on a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Hold for a random gap, then present the item until it is taken.
	task automatic send_sample(input logic [19:0] t, input logic [19:0] p,
			input logic [15:0] h);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= '{temp_raw: t, pressure_raw: p, humidity_raw: h};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted result is back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_wr   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_calibration(input logic [63:0] tc, input logic [63:0] pa,
			input logic [63:0] pb, input logic [63:0] p9, input logic [63:0] hc);
		write_reg(CFG_TEMP, tc);
		write_reg(CFG_PRESS_A, pa);
		write_reg(CFG_PRESS_B, pb);
		write_reg(CFG_P9, p9);
		write_reg(CFG_HUM, hc);
		write_reg(CFG_NONE, {$urandom, $urandom});
		cfg_wr <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Extremes of every raw field plus a few typical samples.
	task automatic directed_samples();
		send_sample(20'h00000, 20'h00000, 16'h0000);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(20'h00000, 20'hFFFFF, 16'h0000);
		send_sample(20'hFFFFF, 20'h00000, 16'hFFFF);
		send_sample(20'h55555, 20'hAAAAA, 16'h5555);
		send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
		send_sample(20'd519888, 20'd415148, 16'd27000);
		send_sample(20'd519888, 20'd300000, 16'd40000);
		send_sample(20'd400000, 20'd500000, 16'd20000);
		send_sample(20'd600000, 20'd250000, 16'd60000);
	endtask

	// Mostly realistic samples near a typical operating point, the rest anything.
	task automatic random_samples(input int count, input bit pause_midway);
		logic [19:0] t, p;
		logic [15:0] h;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				t = 20'd380000 + 20'($urandom_range(0, 280000));
				p = 20'd200000 + 20'($urandom_range(0, 400000));
				h = 16'($urandom_range(15000, 50000));
			end else begin
				t = 20'($urandom);
				p = 20'($urandom);
				h = 16'($urandom);
			end
			send_sample(t, p, h);
			// let the pipe empty once before carrying on
			if (pause_midway && i == count / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
			end
		end
	endtask

	initial begin
		cycles   = 0;
		calm     = 1'b0;
		arst_n   = 1'b0;
		cfg_wr   = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero calibration straight out of reset: divisor is zero
		directed_samples();
		random_samples(100, 1'b0);
		drain();

		load_calibration(64'(TYP_TEMP), TYP_PA, TYP_PB, 64'(TYP_P9), TYP_HUM);
		directed_samples();
		random_samples(400, 1'b1);
		drain();

		// all ones, with bits above the narrow registers' widths
		load_calibration('1, '1, '1, '1, '1);
		directed_samples();
		random_samples(150, 1'b0);
		drain();

		// largest positive coefficients
		load_calibration(64'({16'h7FFF, 16'h7FFF, 16'hFFFF}),
			{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h7FFF}}, 64'(16'h7FFF),
			{8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
		directed_samples();
		random_samples(150, 1'b0);
		drain();

		// most negative coefficients
		load_calibration(64'({16'h8000, 16'h8000, 16'h0000}),
			{16'h8000, 16'h8000, 16'h8000, 16'h0001}, {4{16'h8000}}, 64'(16'h8000),
			{8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00});
		directed_samples();
		random_samples(100, 1'b0);
		drain();

		// typical again at full rate on both sides
		calm = 1'b1;
		load_calibration(64'(TYP_TEMP), TYP_PA, TYP_PB, 64'(TYP_P9), TYP_HUM);
		random_samples(250, 1'b0);
		drain();
		calm = 1'b0;

		// random calibrations
		for (int k = 0; k < 4; k++) begin
			load_calibration(rand64(), rand64(), rand64(), rand64(), rand64());
			random_samples(100, 1'b0);
			drain();
		end

		// let any late item surface before the verdict
		repeat (60) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
